// ===== sv/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_ACK   = 3'd4,
    OP_NACK  = 3'd5,
    OP_WACK  = 3'd6,
    OP_NONE  = 3'd7
  } opcode_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST_A = 5'd1,
    PH_ST_B = 5'd2,
    PH_SP_A = 5'd3,
    PH_SP_B = 5'd4,
    PH_SP_C = 5'd5,
    PH_AK_A = 5'd6,
    PH_AK_B = 5'd7,
    PH_NK_A = 5'd8,
    PH_WA_A = 5'd9,
    PH_WA_B = 5'd10,
    PH_WR_D = 5'd11,
    PH_WR_H = 5'd12,
    PH_RD_L = 5'd13,
    PH_RD_R = 5'd14,
    PH_RD_S = 5'd15
  } phase_t;

  localparam logic [3:0] LAST_BIT = 4'd7;

  // One classified tick as it travels from front to back.
  typedef struct packed {
    logic       cmd_go;
    opcode_t    opcode;
    logic [7:0] tx_byte;
    logic       sda_level;
  } tick_t;

  // One result of a tick.
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } result_t;

endpackage

// ===== sv/i2cms_front.sv =====
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts ticks, flags those that carry a command with a known opcode.
// ----------------------------------------------------------------------------
module i2cms_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd_valid,
  input  logic [2:0]        in_opcode,
  input  logic [7:0]        in_tx_byte,
  input  logic              in_sda_level,
  output logic              push,
  output i2cms_pkg::tick_t  push_tick,
  input  logic              queue_ready
);

  logic             valid_r;
  i2cms_pkg::tick_t tick_r;
  logic             load;

  assign push     = valid_r && queue_ready;
  assign in_stall = valid_r && !queue_ready;
  assign load     = in_valid && !in_stall;
  assign push_tick = tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  // opcode seven carries no command
  always_ff @(posedge clk) begin
    if (load) begin
      tick_r.cmd_go    <= in_cmd_valid && (in_opcode != i2cms_pkg::OP_NONE);
      tick_r.opcode    <= i2cms_pkg::opcode_t'(in_opcode);
      tick_r.tx_byte   <= in_tx_byte;
      tick_r.sda_level <= in_sda_level;
    end
  end

endmodule

// ===== sv/i2cms_queue.sv =====
// ----------------------------------------------------------------------------
// i2cms_queue
// Two-entry queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
module i2cms_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cms_pkg::tick_t  push_tick,
  output logic              ready,
  input  logic              pop,
  output logic              head_valid,
  output i2cms_pkg::tick_t  head_tick
);

  i2cms_pkg::tick_t                  entry_r [i2cms_pkg::QUEUE_DEPTH];
  logic [i2cms_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [i2cms_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [i2cms_pkg::QCNT_W-1:0]      count_r;
  logic                              do_push;
  logic                              do_pop;

  assign ready      = (count_r != i2cms_pkg::QCNT_W'(i2cms_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tick  = entry_r[rd_ptr_r];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_tick;
    end
  end

endmodule

// ===== sv/i2cms_back.sv =====
// ----------------------------------------------------------------------------
// i2cms_back
// Phase sequencer: runs one tick per popped item and registers its result.
// ----------------------------------------------------------------------------
module i2cms_back #(
  parameter int unsigned HOLD_COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  i2cms_pkg::tick_t   head_tick,
  output logic               pop,
  input  logic [15:0]        long_hold,
  input  logic [15:0]        short_hold,
  output logic               out_valid,
  input  logic               out_stall,
  output i2cms_pkg::result_t out_res
);

  localparam int unsigned HW = HOLD_COUNT_WIDTH;

  i2cms_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [HW-1:0]     hold_r, hold_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              ack_r, ack_nxt;
  logic [7:0]        rx_r, rx_nxt;
  logic              done_nxt;
  logic              out_valid_r;
  logic [HW-1:0]     long_ticks;
  logic [HW-1:0]     short_ticks;

  // mask to the counter width; zero holds for one tick
  function automatic logic [HW-1:0] hold_of(input logic [15:0] reg_val);
    logic [HW-1:0] v;
    v = HW'(reg_val);
    return (v == '0) ? HW'(1) : v;
  endfunction

  assign long_ticks  = hold_of(long_hold);
  assign short_ticks = hold_of(short_hold);

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    hold_nxt  = hold_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    done_nxt  = 1'b0;
    if (phase_r == i2cms_pkg::PH_IDLE) begin
      if (head_tick.cmd_go) begin
        unique case (head_tick.opcode)
          i2cms_pkg::OP_START: begin
            scl_nxt = 1'b1; sda_nxt = 1'b1;
            phase_nxt = i2cms_pkg::PH_ST_A; hold_nxt = long_ticks;
          end
          i2cms_pkg::OP_STOP: begin
            scl_nxt = 1'b0; sda_nxt = 1'b0;
            phase_nxt = i2cms_pkg::PH_SP_A; hold_nxt = short_ticks;
          end
          i2cms_pkg::OP_WRITE: begin
            shift_nxt = head_tick.tx_byte; bit_nxt = '0;
            scl_nxt = 1'b0; sda_nxt = head_tick.tx_byte[7];
            phase_nxt = i2cms_pkg::PH_WR_D; hold_nxt = short_ticks;
          end
          i2cms_pkg::OP_READ: begin
            shift_nxt = '0; bit_nxt = '0; scl_nxt = 1'b0;
            phase_nxt = i2cms_pkg::PH_RD_L; hold_nxt = short_ticks;
          end
          i2cms_pkg::OP_ACK: begin
            scl_nxt = 1'b0; sda_nxt = 1'b0;
            phase_nxt = i2cms_pkg::PH_AK_A; hold_nxt = long_ticks;
          end
          i2cms_pkg::OP_NACK: begin
            scl_nxt = 1'b0; sda_nxt = 1'b1;
            phase_nxt = i2cms_pkg::PH_NK_A; hold_nxt = short_ticks;
          end
          i2cms_pkg::OP_WACK: begin
            scl_nxt = 1'b0; sda_nxt = 1'b1;
            phase_nxt = i2cms_pkg::PH_WA_A; hold_nxt = short_ticks;
          end
          default: begin
          end
        endcase
      end
    end else if (hold_r > HW'(1)) begin
      hold_nxt = hold_r - 1'b1;
    end else begin
      unique case (phase_r)
        i2cms_pkg::PH_ST_A: begin
          sda_nxt = 1'b0; phase_nxt = i2cms_pkg::PH_ST_B; hold_nxt = long_ticks;
        end
        i2cms_pkg::PH_ST_B: begin
          scl_nxt = 1'b0; phase_nxt = i2cms_pkg::PH_IDLE; hold_nxt = '0; done_nxt = 1'b1;
        end
        i2cms_pkg::PH_SP_A: begin
          scl_nxt = 1'b1; phase_nxt = i2cms_pkg::PH_SP_B; hold_nxt = long_ticks;
        end
        i2cms_pkg::PH_SP_B: begin
          sda_nxt = 1'b1; phase_nxt = i2cms_pkg::PH_SP_C; hold_nxt = long_ticks;
        end
        i2cms_pkg::PH_SP_C: begin
          phase_nxt = i2cms_pkg::PH_IDLE; hold_nxt = '0; done_nxt = 1'b1;
        end
        i2cms_pkg::PH_AK_A, i2cms_pkg::PH_NK_A: begin
          scl_nxt = 1'b1; phase_nxt = i2cms_pkg::PH_AK_B; hold_nxt = long_ticks;
        end
        i2cms_pkg::PH_AK_B: begin
          scl_nxt = 1'b0; phase_nxt = i2cms_pkg::PH_IDLE; hold_nxt = '0; done_nxt = 1'b1;
        end
        i2cms_pkg::PH_WA_A: begin
          scl_nxt = 1'b1; phase_nxt = i2cms_pkg::PH_WA_B; hold_nxt = short_ticks;
        end
        i2cms_pkg::PH_WA_B: begin
          scl_nxt = 1'b0;
          if (head_tick.sda_level) begin
            ack_nxt = 1'b1; sda_nxt = 1'b0;
            phase_nxt = i2cms_pkg::PH_SP_A; hold_nxt = short_ticks;
          end else begin
            ack_nxt = 1'b0;
            phase_nxt = i2cms_pkg::PH_IDLE; hold_nxt = '0; done_nxt = 1'b1;
          end
        end
        i2cms_pkg::PH_WR_D: begin
          scl_nxt = 1'b1; phase_nxt = i2cms_pkg::PH_WR_H; hold_nxt = short_ticks;
        end
        i2cms_pkg::PH_WR_H: begin
          scl_nxt = 1'b0;
          if (bit_r < i2cms_pkg::LAST_BIT) begin
            bit_nxt   = bit_r + 1'b1;
            shift_nxt = {shift_r[6:0], 1'b0};
            sda_nxt   = shift_r[6];
            phase_nxt = i2cms_pkg::PH_WR_D; hold_nxt = short_ticks;
          end else begin
            phase_nxt = i2cms_pkg::PH_IDLE; hold_nxt = '0; done_nxt = 1'b1;
          end
        end
        i2cms_pkg::PH_RD_L: begin
          sda_nxt = 1'b1; scl_nxt = 1'b1;
          phase_nxt = i2cms_pkg::PH_RD_R; hold_nxt = HW'(1);
        end
        i2cms_pkg::PH_RD_R: begin
          shift_nxt = {shift_r[6:0], head_tick.sda_level};
          phase_nxt = i2cms_pkg::PH_RD_S; hold_nxt = short_ticks;
        end
        i2cms_pkg::PH_RD_S: begin
          if (bit_r < i2cms_pkg::LAST_BIT) begin
            bit_nxt = bit_r + 1'b1; scl_nxt = 1'b0;
            phase_nxt = i2cms_pkg::PH_RD_L; hold_nxt = short_ticks;
          end else begin
            rx_nxt = shift_r;
            phase_nxt = i2cms_pkg::PH_IDLE; hold_nxt = '0; done_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = i2cms_pkg::PH_IDLE; hold_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cms_pkg::PH_IDLE;
      bit_r   <= '0;
      hold_r  <= '0;
      shift_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      rx_r    <= '0;
    end else if (pop) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      hold_r  <= hold_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      rx_r    <= rx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res.scl_level   <= scl_nxt;
      out_res.sda_release <= sda_nxt;
      out_res.busy_res    <= (phase_nxt != i2cms_pkg::PH_IDLE);
      out_res.done_res    <= done_nxt;
      out_res.rx_byte     <= rx_nxt;
      out_res.ack_missing <= ack_nxt;
    end
  end

endmodule

// ===== sv/i2c_master_bit_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// Path: a tick passes the front register, a queue entry and the back result register.
// Throughput: one tick per cycle unless out_stall holds the result; the back
// sequencer updates its phase on every pop, and the two-entry queue absorbs stalls.
// Reset: synchronous, active low; SCL and SDA released high, sequencer idle,
// hold registers back to five (long) and two (short) ticks.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit #(
  parameter int unsigned HOLD_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // tick input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd_valid,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_sda_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_level,
  output logic        out_sda_release,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_byte,
  output logic        out_ack_missing,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_LONG  = 1'b0;
  localparam logic REG_SHORT = 1'b1;

  logic [15:0]        long_hold_r;
  logic [15:0]        short_hold_r;
  logic               cfg_write;
  logic               push;
  i2cms_pkg::tick_t   push_tick;
  logic               queue_ready;
  logic               head_valid;
  i2cms_pkg::tick_t   head_tick;
  logic               pop;
  i2cms_pkg::result_t out_res;

  // Register file: index is the word address, paddr[2].
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_hold_r  <= 16'd5;
      short_hold_r <= 16'd2;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_LONG:  long_hold_r  <= pwdata[15:0];
        REG_SHORT: short_hold_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed hold register.
  always_comb begin
    unique case (paddr[2])
      REG_LONG:  prdata = {16'd0, long_hold_r};
      REG_SHORT: prdata = {16'd0, short_hold_r};
      default:   prdata = '0;
    endcase
  end

  // Front: take tick transactions, flag real commands.
  i2cms_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd_valid (in_cmd_valid),
    .in_opcode    (in_opcode),
    .in_tx_byte   (in_tx_byte),
    .in_sda_level (in_sda_level),
    .push         (push),
    .push_tick    (push_tick),
    .queue_ready  (queue_ready)
  );

  // Queue: decouple front acceptance from result backpressure.
  i2cms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tick  (push_tick),
    .ready      (queue_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tick  (head_tick)
  );

  // Back: advance the phase sequencer one tick per popped transaction.
  i2cms_back #(
    .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_tick  (head_tick),
    .pop        (pop),
    .long_hold  (long_hold_r),
    .short_hold (short_hold_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_scl_level   = out_res.scl_level;
  assign out_sda_release = out_res.sda_release;
  assign out_busy_res    = out_res.busy_res;
  assign out_done_res    = out_res.done_res;
  assign out_rx_byte     = out_res.rx_byte;
  assign out_ack_missing = out_res.ack_missing;

endmodule

// ===== sim/i2c_master_bit_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit_tb
// Self-checking bench for the I2C master bit sequencer. Every tick transaction
// runs through an in-bench copy of the phase sequencer. The predicted SCL/SDA
// levels and status go into a queue, and each result transaction is checked
// against the oldest entry. A directed command table comes first. Random bus
// frames with noise and ignored busy commands follow, under several hold
// settings that include zero holds. Full-scale holds are written and read
// back last.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit_tb;

  // Register indexes of the configuration port (byte address is 4 * index).
  localparam int REG_LONG_HOLD  = 0;
  localparam int REG_SHORT_HOLD = 1;

  // Wait margin for register access and drain, and the quiet-cycle limit.
  localparam int DUT_LATENCY    = 2;
  localparam int QUIET_LIMIT    = 3000;
  localparam int BACKLOG_HOLD   = 150;
  localparam int BACKLOG_AFTER  = 200;

  // Pin and status levels that can be read straight off the sequences.
  localparam i2cms_pkg::result_t BUS_REST = '{scl_level: 1'b1, sda_release: 1'b1,
                                              busy_res: 1'b0, done_res: 1'b0,
                                              rx_byte: 8'h00, ack_missing: 1'b0};
  localparam i2cms_pkg::result_t START_FIRST = '{scl_level: 1'b1, sda_release: 1'b1,
                                                 busy_res: 1'b1, done_res: 1'b0,
                                                 rx_byte: 8'h00, ack_missing: 1'b0};
  localparam i2cms_pkg::result_t SCL_LOW_SDA_REL = '{scl_level: 1'b0, sda_release: 1'b1,
                                                     busy_res: 1'b1, done_res: 1'b0,
                                                     rx_byte: 8'h00, ack_missing: 1'b0};
  localparam i2cms_pkg::result_t SCL_LOW_SDA_LOW = '{scl_level: 1'b0, sda_release: 1'b0,
                                                     busy_res: 1'b1, done_res: 1'b0,
                                                     rx_byte: 8'h00, ack_missing: 1'b0};

  // One row of the directed table: a command and the bits the slave puts on SDA.
  typedef struct packed {
    logic               cmd_valid;
    i2cms_pkg::opcode_t opcode;
    logic [7:0]         tx_byte;
    logic [7:0]         slave_bits;
    logic               typed;
    i2cms_pkg::result_t first_result;
  } cmd_row_t;

  typedef struct packed {
    logic [31:0] long_word;
    logic [31:0] short_word;
    logic [15:0] ticks;
    logic        no_gaps;
  } hold_setting_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd_valid;
  logic [2:0]  in_opcode;
  logic [7:0]  in_tx_byte;
  logic        in_sda_level;
  logic        out_valid;
  logic        out_stall;
  logic        out_scl_level;
  logic        out_sda_release;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_rx_byte;
  logic        out_ack_missing;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Sequencer copy: hold settings plus the phase machine state.
  logic [15:0]       long_ticks  = 16'd5;
  logic [15:0]       short_ticks = 16'd2;
  i2cms_pkg::phase_t seq_phase   = i2cms_pkg::PH_IDLE;
  logic [3:0]        bit_num     = 4'd0;
  logic [15:0]       hold_cnt    = 16'd0;
  logic [7:0]        shift_q     = 8'h00;
  logic              scl_q       = 1'b1;
  logic              sda_q       = 1'b1;
  logic              ack_q       = 1'b0;
  logic              done_q      = 1'b0;
  logic [7:0]        rx_q        = 8'h00;

  i2cms_pkg::result_t pin_states_due[$];
  int unsigned mismatches    = 0;
  int unsigned ticks_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned launches      = 0;
  int unsigned reads_run     = 0;
  int unsigned missing_acks  = 0;
  int unsigned settings_used = 1;
  int unsigned quiet_cycles  = 0;
  bit          steady_flow   = 1'b0;
  bit          backlog_done  = 1'b0;

  i2c_master_bit_sequencer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd_valid   (in_cmd_valid),
    .in_opcode      (in_opcode),
    .in_tx_byte     (in_tx_byte),
    .in_sda_level   (in_sda_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scl_level  (out_scl_level),
    .out_sda_release(out_sda_release),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_rx_byte    (out_rx_byte),
    .out_ack_missing(out_ack_missing),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk = ~clk;

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Enter a phase and load its hold; a zero hold register counts as one tick.
  task automatic load_phase(input i2cms_pkg::phase_t next, input logic [15:0] hold_reg);
    seq_phase = next;
    hold_cnt  = (hold_reg == 16'd0) ? 16'd1 : hold_reg;
  endtask

  task automatic end_command();
    seq_phase = i2cms_pkg::PH_IDLE;
    hold_cnt  = 16'd0;
    done_q    = 1'b1;
  endtask

  // Advance the sequencer by one tick and return the levels it shows after it.
  task automatic step_sequencer(input logic cv, input logic [2:0] op, input logic [7:0] tx,
                                input logic sda, output i2cms_pkg::result_t levels);
    done_q = 1'b0;
    if (seq_phase == i2cms_pkg::PH_IDLE) begin
      // Launch only from idle; opcode 7 is dropped.
      if (cv && op != i2cms_pkg::OP_NONE) begin
        launches++;
        case (i2cms_pkg::opcode_t'(op))
          i2cms_pkg::OP_START: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            load_phase(i2cms_pkg::PH_ST_A, long_ticks);
          end
          i2cms_pkg::OP_STOP: begin
            scl_q = 1'b0;
            sda_q = 1'b0;
            load_phase(i2cms_pkg::PH_SP_A, short_ticks);
          end
          i2cms_pkg::OP_WRITE: begin
            shift_q = tx;
            bit_num = 4'd0;
            scl_q   = 1'b0;
            sda_q   = tx[7];
            load_phase(i2cms_pkg::PH_WR_D, short_ticks);
          end
          i2cms_pkg::OP_READ: begin
            reads_run++;
            shift_q = 8'h00;
            bit_num = 4'd0;
            scl_q   = 1'b0;
            load_phase(i2cms_pkg::PH_RD_L, short_ticks);
          end
          i2cms_pkg::OP_ACK: begin
            scl_q = 1'b0;
            sda_q = 1'b0;
            load_phase(i2cms_pkg::PH_AK_A, long_ticks);
          end
          i2cms_pkg::OP_NACK: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
            load_phase(i2cms_pkg::PH_NK_A, short_ticks);
          end
          i2cms_pkg::OP_WACK: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
            load_phase(i2cms_pkg::PH_WA_A, short_ticks);
          end
          default: ;
        endcase
      end
    end else if (hold_cnt > 16'd1) begin
      hold_cnt--;
    end else begin
      case (seq_phase)
        i2cms_pkg::PH_ST_A: begin
          sda_q = 1'b0;
          load_phase(i2cms_pkg::PH_ST_B, long_ticks);
        end
        i2cms_pkg::PH_ST_B: begin
          scl_q = 1'b0;
          end_command();
        end
        i2cms_pkg::PH_SP_A: begin
          scl_q = 1'b1;
          load_phase(i2cms_pkg::PH_SP_B, long_ticks);
        end
        i2cms_pkg::PH_SP_B: begin
          sda_q = 1'b1;
          load_phase(i2cms_pkg::PH_SP_C, long_ticks);
        end
        i2cms_pkg::PH_SP_C: end_command();
        i2cms_pkg::PH_AK_A, i2cms_pkg::PH_NK_A: begin
          scl_q = 1'b1;
          load_phase(i2cms_pkg::PH_AK_B, long_ticks);
        end
        i2cms_pkg::PH_AK_B: begin
          scl_q = 1'b0;
          end_command();
        end
        i2cms_pkg::PH_WA_A: begin
          scl_q = 1'b1;
          load_phase(i2cms_pkg::PH_WA_B, short_ticks);
        end
        i2cms_pkg::PH_WA_B: begin
          // SDA high at the ack slot: flag it and fall into a stop sequence.
          scl_q = 1'b0;
          if (sda) begin
            missing_acks++;
            ack_q = 1'b1;
            sda_q = 1'b0;
            load_phase(i2cms_pkg::PH_SP_A, short_ticks);
          end else begin
            ack_q = 1'b0;
            end_command();
          end
        end
        i2cms_pkg::PH_WR_D: begin
          scl_q = 1'b1;
          load_phase(i2cms_pkg::PH_WR_H, short_ticks);
        end
        i2cms_pkg::PH_WR_H: begin
          scl_q = 1'b0;
          if (bit_num < i2cms_pkg::LAST_BIT) begin
            bit_num = bit_num + 4'd1;
            shift_q = {shift_q[6:0], 1'b0};
            sda_q   = shift_q[7];
            load_phase(i2cms_pkg::PH_WR_D, short_ticks);
          end else begin
            end_command();
          end
        end
        i2cms_pkg::PH_RD_L: begin
          // Release SDA, raise SCL and enter the sample phase for exactly one tick.
          sda_q     = 1'b1;
          scl_q     = 1'b1;
          seq_phase = i2cms_pkg::PH_RD_R;
          hold_cnt  = 16'd1;
        end
        i2cms_pkg::PH_RD_R: begin
          shift_q = {shift_q[6:0], sda};
          load_phase(i2cms_pkg::PH_RD_S, short_ticks);
        end
        i2cms_pkg::PH_RD_S: begin
          if (bit_num < i2cms_pkg::LAST_BIT) begin
            bit_num = bit_num + 4'd1;
            scl_q   = 1'b0;
            load_phase(i2cms_pkg::PH_RD_L, short_ticks);
          end else begin
            rx_q = shift_q;
            end_command();
          end
        end
        default: begin
          seq_phase = i2cms_pkg::PH_IDLE;
          hold_cnt  = 16'd0;
        end
      endcase
    end
    levels.scl_level   = scl_q;
    levels.sda_release = sda_q;
    levels.busy_res    = (seq_phase != i2cms_pkg::PH_IDLE);
    levels.done_res    = done_q;
    levels.rx_byte     = rx_q;
    levels.ack_missing = ack_q;
  endtask

  // Offer one tick after a random gap and hold it until the block takes it.
  task automatic send_tick(input logic cv, input logic [2:0] op, input logic [7:0] tx,
                           input logic sda, input logic typed,
                           input i2cms_pkg::result_t typed_levels);
    int unsigned        gap;
    i2cms_pkg::result_t levels;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd_valid <= cv;
    in_opcode    <= op;
    in_tx_byte   <= tx;
    in_sda_level <= sda;
    do @(posedge clk); while (in_stall !== 1'b0);
    ticks_sent++;
    step_sequencer(cv, op, tx, sda, levels);
    pin_states_due.push_back(typed ? typed_levels : levels);
  endtask

  // Issue one command, then keep ticking until the sequencer is idle again.
  // Follow-up ticks carry random commands, which the busy block must drop.
  // The slave drives slave_bits MSB first in read sample slots, bit 0 elsewhere.
  task automatic issue_command(input logic cv, input logic [2:0] op, input logic [7:0] tx,
                               input logic [7:0] slave_bits, input logic typed,
                               input i2cms_pkg::result_t typed_levels);
    logic sda;
    send_tick(cv, op, tx, 1'($urandom), typed, typed_levels);
    while (seq_phase != i2cms_pkg::PH_IDLE) begin
      sda = (seq_phase == i2cms_pkg::PH_RD_R) ?
            slave_bits[3'(i2cms_pkg::LAST_BIT - bit_num)] : slave_bits[0];
      send_tick(1'($urandom), 3'($urandom), 8'($urandom), sda, 1'b0, BUS_REST);
    end
  endtask

  // Write a hold register while the block is quiet, then read it back.
  task automatic write_hold_reg(input int reg_idx, input logic [31:0] value);
    logic [15:0] stored;
    in_valid <= 1'b0;
    while (pin_states_due.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 2) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(reg_idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (reg_idx == REG_LONG_HOLD) begin
      long_ticks = value[15:0];
    end else begin
      short_ticks = value[15:0];
    end
    stored = value[15:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[15:0] !== stored) begin
      note_mismatch($sformatf("hold register %0d: expected %04h, read %04h",
                              reg_idx, stored, prdata[15:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic: mostly well-formed frames, the rest lone or junk commands.
  task automatic run_random_frames(input int unsigned budget);
    int unsigned stop_at;
    int unsigned n_data;
    bit          reading;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        issue_command(1'($urandom), 3'($urandom), 8'($urandom), 8'($urandom), 1'b0, BUS_REST);
      end else begin
        n_data  = $urandom_range(0, 3);
        reading = 1'($urandom);
        issue_command(1'b1, i2cms_pkg::OP_START, 8'($urandom), 8'($urandom), 1'b0,
                      BUS_REST);
        issue_command(1'b1, i2cms_pkg::OP_WRITE, 8'($urandom), 8'($urandom), 1'b0,
                      BUS_REST);
        issue_command(1'b1, i2cms_pkg::OP_WACK, 8'($urandom), 8'($urandom), 1'b0,
                      BUS_REST);
        for (int i = 0; i < n_data; i++) begin
          if (reading) begin
            issue_command(1'b1, i2cms_pkg::OP_READ, 8'($urandom), 8'($urandom), 1'b0,
                          BUS_REST);
            issue_command(1'b1, (i == n_data - 1) ? i2cms_pkg::OP_NACK : i2cms_pkg::OP_ACK,
                          8'($urandom), 8'($urandom), 1'b0, BUS_REST);
          end else begin
            issue_command(1'b1, i2cms_pkg::OP_WRITE, 8'($urandom), 8'($urandom), 1'b0,
                          BUS_REST);
            issue_command(1'b1, i2cms_pkg::OP_WACK, 8'($urandom), 8'($urandom), 1'b0,
                          BUS_REST);
          end
        end
        issue_command(1'b1, i2cms_pkg::OP_STOP, 8'($urandom), 8'($urandom), 1'b0,
                      BUS_REST);
      end
    end
  endtask

  // Stimulus: directed table, random frames under several hold settings,
  // then both holds written at full scale and read back.
  initial begin : stimulus
    cmd_row_t      steps [18];
    hold_setting_t plan  [5];
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_cmd_valid <= 1'b0;
    in_opcode    <= i2cms_pkg::OP_NONE;
    in_tx_byte   <= 8'h00;
    in_sda_level <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= 3'd0;
    pwdata       <= 32'd0;

    // Idle tick, ignored opcode 7, then frames with present and missing acks.
    steps[0]  = '{1'b0, i2cms_pkg::OP_START, 8'h00, 8'h00, 1'b1, BUS_REST};
    steps[1]  = '{1'b1, i2cms_pkg::OP_NONE,  8'hFF, 8'h00, 1'b1, BUS_REST};
    steps[2]  = '{1'b1, i2cms_pkg::OP_START, 8'h00, 8'h00, 1'b1, START_FIRST};
    steps[3]  = '{1'b1, i2cms_pkg::OP_WRITE, 8'hA5, 8'h00, 1'b1, SCL_LOW_SDA_REL};
    steps[4]  = '{1'b1, i2cms_pkg::OP_WACK,  8'h00, 8'h00, 1'b1, SCL_LOW_SDA_REL};
    steps[5]  = '{1'b1, i2cms_pkg::OP_WRITE, 8'h00, 8'h00, 1'b1, SCL_LOW_SDA_LOW};
    steps[6]  = '{1'b1, i2cms_pkg::OP_WACK,  8'h00, 8'h00, 1'b1, SCL_LOW_SDA_REL};
    steps[7]  = '{1'b1, i2cms_pkg::OP_WRITE, 8'hFF, 8'h00, 1'b1, SCL_LOW_SDA_REL};
    steps[8]  = '{1'b1, i2cms_pkg::OP_WACK,  8'h00, 8'hFF, 1'b0, BUS_REST};
    steps[9]  = '{1'b1, i2cms_pkg::OP_START, 8'h00, 8'h00, 1'b0, BUS_REST};
    steps[10] = '{1'b1, i2cms_pkg::OP_READ,  8'h00, 8'hFF, 1'b0, BUS_REST};
    steps[11] = '{1'b1, i2cms_pkg::OP_ACK,   8'h00, 8'h00, 1'b0, BUS_REST};
    steps[12] = '{1'b1, i2cms_pkg::OP_READ,  8'h00, 8'h00, 1'b0, BUS_REST};
    steps[13] = '{1'b1, i2cms_pkg::OP_NACK,  8'h00, 8'h00, 1'b0, BUS_REST};
    steps[14] = '{1'b1, i2cms_pkg::OP_READ,  8'h00, 8'h5A, 1'b0, BUS_REST};
    steps[15] = '{1'b1, i2cms_pkg::OP_WACK,  8'h00, 8'h00, 1'b0, BUS_REST};
    steps[16] = '{1'b1, i2cms_pkg::OP_STOP,  8'h00, 8'h00, 1'b0, BUS_REST};
    steps[17] = '{1'b0, i2cms_pkg::OP_WRITE, 8'h3C, 8'h00, 1'b0, BUS_REST};

    // Shortest holds, zero holds, junk in the upper bits, reset values, mixed.
    plan[0] = '{32'h0000_0001, 32'h0000_0001, 16'd150, 1'b0};
    plan[1] = '{32'h0000_0000, 32'h0000_0000, 16'd100, 1'b1};
    plan[2] = '{32'hABCD_0003, 32'h5432_0004, 16'd150, 1'b0};
    plan[3] = '{32'h0000_0005, 32'h0000_0002, 16'd120, 1'b0};
    plan[4] = '{32'hFFFF_0002, 32'h0000_0001, 16'd100, 1'b1};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      issue_command(steps[i].cmd_valid, steps[i].opcode, steps[i].tx_byte,
                    steps[i].slave_bits, steps[i].typed, steps[i].first_result);
    end

    foreach (plan[i]) begin
      write_hold_reg(REG_LONG_HOLD, plan[i].long_word);
      write_hold_reg(REG_SHORT_HOLD, plan[i].short_word);
      settings_used++;
      steady_flow = plan[i].no_gaps;
      run_random_frames(plan[i].ticks);
    end

    // Full-scale holds: written and read back only.
    write_hold_reg(REG_LONG_HOLD, 32'h0000_FFFF);
    write_hold_reg(REG_SHORT_HOLD, 32'h0000_FFFF);
    settings_used++;

    in_valid <= 1'b0;
    while (pin_states_due.size() != 0) @(posedge clk);
    repeat (2 * DUT_LATENCY + 4) @(posedge clk);

    $display("covered %0d ticks and %0d launched commands (%0d reads, %0d missing acks)",
             ticks_sent, launches, reads_run, missing_acks);
    $display("over %0d hold settings; %0d results checked", settings_used, results_seen);
    if (mismatches == 0) begin
      $display("i2c_master_bit_sequencer_unit: match");
    end else begin
      $display("i2c_master_bit_sequencer_unit: mismatch");
    end
    $finish;
  end

  // Result side: random stall per transaction, one long hold-off to back up
  // the block, and a check of every result against the oldest prediction.
  initial begin : result_check
    int unsigned        hold;
    i2cms_pkg::result_t got;
    i2cms_pkg::result_t want;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 9);
      if (!backlog_done && results_seen >= BACKLOG_AFTER) begin
        backlog_done = 1'b1;
        hold = BACKLOG_HOLD;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{scl_level: out_scl_level, sda_release: out_sda_release,
              busy_res: out_busy_res, done_res: out_done_res,
              rx_byte: out_rx_byte, ack_missing: out_ack_missing};
      results_seen++;
      if (pin_states_due.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pin_states_due.pop_front();
        if (got !== want) begin
          note_mismatch($sformatf({"result %0d: expected scl=%b sda=%b busy=%b done=%b ",
                                   "rx=%02h nack=%b, got scl=%b sda=%b busy=%b done=%b ",
                                   "rx=%02h nack=%b"}, results_seen,
                                  want.scl_level, want.sda_release, want.busy_res,
                                  want.done_res, want.rx_byte, want.ack_missing,
                                  got.scl_level, got.sda_release, got.busy_res,
                                  got.done_res, got.rx_byte, got.ack_missing));
        end
      end
    end
  end

  // Watchdog: drop the run if no transaction and no register access moves.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results pending",
               quiet_cycles, pin_states_due.size());
      $display("i2c_master_bit_sequencer_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
